### rtl/core/mean_and_nearest_index_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mean and nearest index block
// Immediate-implication and next-cycle-implication checks on clk / arst_n.
// ----------------------------------------------------------------------------
`ifndef MEAN_AND_NEAREST_INDEX_MACROS_SVH
`define MEAN_AND_NEAREST_INDEX_MACROS_SVH

// ante holds -> cons holds in the same cycle
`define MANI_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mean_and_nearest_index: same-cycle check failed");

// ante holds -> cons holds in the next cycle
`define MANI_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mean_and_nearest_index: next-cycle check failed");

`endif

### rtl/core/mani_pkg.sv
// ----------------------------------------------------------------------------
// mani_pkg
// Shared widths and the flow-control struct between the front and back parts.
// ----------------------------------------------------------------------------
package mani_pkg;

	localparam int SAMPLE_W = 16;
	localparam int FRAC_W   = 8;
	localparam int MEAN_W   = 24;
	localparam int INDEX_W  = 8;
	localparam int DIST_W   = 25;

	typedef struct packed {
		logic queue_empty;
		logic back_busy;
	} flow_t;

endpackage

### rtl/core/mean_and_nearest_index.sv
// Samples are taken one per cycle while no run is being evaluated.
// After the beat marked last, a run of N samples is divided in the bit-serial
// divider and then the store is scanned for the nearest sample, then the result
// beat is registered; the store has one read port, which paces the scan.
// New samples stall from the last beat until the scan ends.
// arst_n clears the sum, count, queue, sequencer and result valid; the store is not cleared.
// ----------------------------------------------------------------------------
// mean_and_nearest_index
// Mean of a marked run of samples in Q8 and the index of the sample nearest it.
// ----------------------------------------------------------------------------
`include "mean_and_nearest_index_macros.svh"

module mean_and_nearest_index #(
	parameter int MAX_ITEMS = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic signed [mani_pkg::SAMPLE_W-1:0] sample_value,
	input  logic                                 last_item,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [mani_pkg::MEAN_W-1:0]   mean_q8,
	output logic        [mani_pkg::INDEX_W-1:0]  nearest_index
);

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int SW = mani_pkg::SAMPLE_W + CW;
	localparam int JW = SW + CW;

	mani_pkg::flow_t        flow;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [mani_pkg::SAMPLE_W-1:0] wr_data;
	logic                   push;
	logic signed [SW-1:0]   push_sum;
	logic [CW-1:0]          push_count;
	logic                   pop;
	logic                   busy;
	logic [JW-1:0]          job;
	logic                   q_empty;
	logic                   q_full;

	assign flow.queue_empty = q_empty;
	assign flow.back_busy   = busy;

	mani_front #(
		.MAX_ITEMS (MAX_ITEMS),
		.CW        (CW),
		.AW        (AW),
		.SW        (SW)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_value (sample_value),
		.last_item    (last_item),
		.flow         (flow),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.push         (push),
		.push_sum     (push_sum),
		.push_count   (push_count)
	);

	mani_queue #(
		.WIDTH (JW),
		.DEPTH (2)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    ({push_sum, push_count}),
		.pop    (pop),
		.dout   (job),
		.empty  (q_empty),
		.full   (q_full)
	);

	mani_back #(
		.MAX_ITEMS (MAX_ITEMS),
		.CW        (CW),
		.AW        (AW),
		.SW        (SW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.job_valid     (!q_empty),
		.job_sum       (job[JW-1:CW]),
		.job_count     (job[CW-1:0]),
		.pop           (pop),
		.busy          (busy),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.mean_q8       (mean_q8),
		.nearest_index (nearest_index)
	);

	`MANI_ASSERT_IMP(a_no_write_during_scan, wr_en, !busy)
	`MANI_ASSERT_IMP(a_no_queue_overflow, push, !q_full)
	`MANI_ASSERT_NXT(a_pop_starts_work, pop, busy)
	`MANI_ASSERT_IMP(a_job_count_nonzero, pop, job[CW-1:0] != '0)

endmodule

### rtl/core/mani_front.sv
// ----------------------------------------------------------------------------
// mani_front
// Accepts sample beats, writes the store, keeps the running sum and count,
// and hands a finished run to the job queue.
// ----------------------------------------------------------------------------
module mani_front #(
	parameter int MAX_ITEMS = 256,
	parameter int CW        = 9,
	parameter int AW        = 8,
	parameter int SW        = 25
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic signed [mani_pkg::SAMPLE_W-1:0] sample_value,
	input  logic                                 last_item,
	input  mani_pkg::flow_t                      flow,
	output logic                                 wr_en,
	output logic        [AW-1:0]                 wr_addr,
	output logic        [mani_pkg::SAMPLE_W-1:0] wr_data,
	output logic                                 push,
	output logic signed [SW-1:0]                 push_sum,
	output logic        [CW-1:0]                 push_count
);

	logic signed [SW-1:0] sum_q;
	logic        [CW-1:0] count_q;
	logic                 accept;
	logic                 room;
	logic signed [SW-1:0] addend;
	logic signed [SW-1:0] sum_next;
	logic        [CW-1:0] count_next;

	assign sample_stall = !flow.queue_empty || flow.back_busy;
	assign accept       = sample_valid && !sample_stall;
	assign room         = count_q < CW'(MAX_ITEMS);

	assign addend     = room ? {{(SW-mani_pkg::SAMPLE_W){sample_value[mani_pkg::SAMPLE_W-1]}},
		sample_value} : '0;
	assign sum_next   = sum_q + addend;
	assign count_next = count_q + CW'(room);

	assign wr_en      = accept && room;
	assign wr_addr    = count_q[AW-1:0];
	assign wr_data    = sample_value;
	assign push       = accept && last_item;
	assign push_sum   = sum_next;
	assign push_count = count_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (last_item) begin
				sum_q   <= '0;
				count_q <= '0;
			end else begin
				sum_q   <= sum_next;
				count_q <= count_next;
			end
		end
	end

endmodule

### rtl/core/mani_queue.sv
// ----------------------------------------------------------------------------
// mani_queue
// Short first-in first-out job queue between the front and back parts.
// ----------------------------------------------------------------------------
module mani_queue #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty,
	output logic             full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    fill_q;
	logic             do_push;
	logic             do_pop;

	assign empty   = fill_q == '0;
	assign full    = fill_q == NW'(DEPTH);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			fill_q <= fill_q + NW'(do_push) - NW'(do_pop);
		end
	end

endmodule

### rtl/core/mani_back.sv
// ----------------------------------------------------------------------------
// mani_back
// Holds the sample store, divides sum by count one bit per cycle, scans the
// store for the sample nearest to the mean and registers the result beat.
// ----------------------------------------------------------------------------
module mani_back #(
	parameter int MAX_ITEMS = 256,
	parameter int CW        = 9,
	parameter int AW        = 8,
	parameter int SW        = 25
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic        [AW-1:0]                 wr_addr,
	input  logic        [mani_pkg::SAMPLE_W-1:0] wr_data,
	input  logic                                 job_valid,
	input  logic signed [SW-1:0]                 job_sum,
	input  logic        [CW-1:0]                 job_count,
	output logic                                 pop,
	output logic                                 busy,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [mani_pkg::MEAN_W-1:0]   mean_q8,
	output logic        [mani_pkg::INDEX_W-1:0]  nearest_index
);

	localparam int DW  = SW + mani_pkg::FRAC_W;
	localparam int STW = $clog2(DW);
	localparam int MW  = mani_pkg::MEAN_W;
	localparam int XW  = mani_pkg::DIST_W + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [mani_pkg::SAMPLE_W-1:0] mem [MAX_ITEMS];

	logic [1:0]                      state_q;
	logic [DW-1:0]                   dvd_q;
	logic [CW-1:0]                   rem_q;
	logic [CW-1:0]                   divisor_q;
	logic [STW-1:0]                  step_q;
	logic                            neg_q;
	logic signed [MW-1:0]            mean_q;
	logic [CW-1:0]                   addr_q;
	logic                            first_q;
	logic [mani_pkg::DIST_W-1:0]     best_dist_q;
	logic [AW-1:0]                   best_idx_q;
	logic [mani_pkg::SAMPLE_W-1:0]   rd_data_s1;
	logic [AW-1:0]                   rd_idx_s1;
	logic                            rd_vld_s1;
	logic                            result_valid_q;
	logic signed [MW-1:0]            mean_out_q;
	logic [mani_pkg::INDEX_W-1:0]    index_out_q;

	logic signed [DW-1:0]            num;
	logic [DW-1:0]                   num_mag;
	logic [CW:0]                     rem_sh;
	logic [CW:0]                     rem_sub;
	logic                            qbit;
	logic [DW-1:0]                   dvd_next;
	logic [MW-1:0]                   quo;
	logic [MW-1:0]                   quo_neg;
	logic                            issue;
	logic signed [XW-1:0]            scaled;
	logic signed [XW-1:0]            diff;
	logic signed [XW-1:0]            diff_neg;
	logic [mani_pkg::DIST_W-1:0]     cand_dist;
	logic                            take;
	logic                            load_out;

	assign num     = {job_sum, {mani_pkg::FRAC_W{1'b0}}};
	assign num_mag = num[DW-1] ? DW'(-num) : num;

	assign rem_sh   = {rem_q, dvd_q[DW-1]};
	assign rem_sub  = rem_sh - {1'b0, divisor_q};
	assign qbit     = rem_sh >= {1'b0, divisor_q};
	assign dvd_next = {dvd_q[DW-2:0], qbit};
	assign quo      = dvd_next[MW-1:0];
	assign quo_neg  = ~quo + MW'(1);

	assign issue = (state_q == ST_SCAN) && (addr_q < divisor_q);

	assign scaled    = {{(XW-mani_pkg::SAMPLE_W-mani_pkg::FRAC_W){rd_data_s1[mani_pkg::SAMPLE_W-1]}},
		rd_data_s1, {mani_pkg::FRAC_W{1'b0}}};
	assign diff      = scaled - {{(XW-MW){mean_q[MW-1]}}, mean_q};
	assign diff_neg  = -diff;
	assign cand_dist = diff[XW-1] ? diff_neg[mani_pkg::DIST_W-1:0] : diff[mani_pkg::DIST_W-1:0];
	assign take      = rd_vld_s1 && (first_q || (cand_dist < best_dist_q));

	assign pop      = (state_q == ST_IDLE) && job_valid;
	assign busy     = (state_q == ST_DIV) || (state_q == ST_SCAN);
	assign load_out = (state_q == ST_DONE) && (!result_valid_q || !result_stall);

	assign result_valid  = result_valid_q;
	assign mean_q8       = mean_out_q;
	assign nearest_index = index_out_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem[addr_q[AW-1:0]];
		rd_idx_s1  <= addr_q[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			neg_q     <= job_sum[SW-1];
			dvd_q     <= num_mag;
			divisor_q <= job_count;
			rem_q     <= '0;
			step_q    <= STW'(DW - 1);
		end else if (state_q == ST_DIV) begin
			dvd_q  <= dvd_next;
			rem_q  <= qbit ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
			step_q <= step_q - STW'(1);
			if (step_q == '0) begin
				mean_q <= neg_q ? quo_neg : quo;
			end
		end
		if (take) begin
			best_dist_q <= cand_dist;
			best_idx_q  <= rd_idx_s1;
		end
		if (load_out) begin
			mean_out_q  <= mean_q;
			index_out_q <= mani_pkg::INDEX_W'(best_idx_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			addr_q         <= '0;
			first_q        <= 1'b0;
			rd_vld_s1      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				addr_q <= addr_q + CW'(1);
			end
			if (take) begin
				first_q <= 1'b0;
			end
			if (load_out) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_SCAN;
						addr_q  <= '0;
						first_q <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (!issue && !rd_vld_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### tb/sv/tb_mean_and_nearest_index.sv
// ----------------------------------------------------------------------------
// tb_mean_and_nearest_index
// Self-checking bench for the mean and nearest index block. A short table of
// runs probes the extremes, truncation of negative means, ties and mixed
// signs. Random runs follow, one of them long enough to overflow the sample
// store. The Q8 mean and the index of the first nearest sample are predicted
// per run and matched against each result beat in order. Random idle bursts
// on both handshakes and one long result hold-off fill the block up.
// ----------------------------------------------------------------------------
module tb_mean_and_nearest_index;

	localparam int HELD_DEPTH   = 256;
	localparam int DIRECTED_N   = 16;
	localparam int RANDOM_RUNS  = 56;
	localparam int LONG_RUN     = 3;
	localparam int QUIET_RUNS   = 8;
	localparam int HOLD_CYCLES  = 600;
	localparam int DRAIN_CYCLES = 400;

	typedef logic signed [mani_pkg::SAMPLE_W-1:0] sample_t;
	typedef logic signed [mani_pkg::MEAN_W-1:0]   mean_t;

	typedef struct packed {
		logic signed [mani_pkg::MEAN_W-1:0] mean_q8;
		logic [mani_pkg::INDEX_W-1:0]       idx;
	} mean_idx_t;

	typedef struct {
		sample_t                      value;
		int                           reps;
		bit                           last;
		bit                           typed;
		mean_t                        mean_q8;
		logic [mani_pkg::INDEX_W-1:0] idx;
	} stim_row_t;

	typedef enum {FILL_FULL, FILL_NARROW, FILL_EXTREME} fill_mode_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         sample_valid = 1'b0;
	logic                         sample_stall;
	sample_t                      sample_value = '0;
	logic                         last_item = 1'b0;
	logic                         result_valid;
	logic                         result_stall = 1'b0;
	mean_t                        mean_q8;
	logic [mani_pkg::INDEX_W-1:0] nearest_index;

	sample_t                    held_samples [HELD_DEPTH];
	mean_t                      acc_sum = '0;
	logic [8:0]                 acc_count = '0;
	mean_idx_t                  pending_results [$];
	int                         mismatches = 0;
	bit                         idle_on = 1'b1;
	bit                         hold_req = 1'b0;
	bit                         hold_done = 1'b0;

	stim_row_t directed_rows [DIRECTED_N] = '{
		'{32767, 1, 1, 1, 8388352, 0},
		'{-32768, 1, 1, 1, -8388608, 0},
		'{0, 1, 1, 1, 0, 0},
		'{1, 1, 0, 0, 0, 0},
		'{2, 1, 1, 1, 384, 0},
		'{-1, 1, 0, 0, 0, 0},
		'{0, 2, 1, 1, -85, 1},
		'{32767, 1, 0, 0, 0, 0},
		'{-32768, 1, 1, 1, -128, 0},
		'{-7, 3, 1, 1, -1792, 0},
		'{-3, 1, 0, 0, 0, 0},
		'{4, 1, 0, 0, 0, 0},
		'{-5, 1, 0, 0, 0, 0},
		'{12345, 1, 1, 0, 0, 0},
		'{-21846, 1, 0, 0, 0, 0},
		'{21845, 1, 1, 0, 0, 0}
	};

	mean_and_nearest_index #(.MAX_ITEMS(HELD_DEPTH)) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_value (sample_value),
		.last_item    (last_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.mean_q8      (mean_q8),
		.nearest_index(nearest_index)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic absorb_sample(input sample_t v, input bit l,
			output bit has_res, output mean_idx_t res);
		longint q8;
		longint best;
		longint d;
		int     best_k;
		has_res = 1'b0;
		res = '0;
		// drop beats once the store is full
		if (acc_count < HELD_DEPTH) begin
			held_samples[acc_count[7:0]] = v;
			acc_sum = acc_sum + mean_t'(v);
			acc_count = acc_count + 9'd1;
		end
		if (l) begin
			q8 = (longint'(acc_sum) * 256) / longint'(acc_count);
			best = longint'(held_samples[0]) * 256 - q8;
			if (best < 0) best = -best;
			best_k = 0;
			for (int k = 1; k < acc_count; k++) begin
				d = longint'(held_samples[k]) * 256 - q8;
				if (d < 0) d = -d;
				if (d < best) begin
					best = d;
					best_k = k;
				end
			end
			res.mean_q8 = q8[mani_pkg::MEAN_W-1:0];
			res.idx = best_k[mani_pkg::INDEX_W-1:0];
			has_res = 1'b1;
			acc_sum = '0;
			acc_count = '0;
		end
	endtask

	task automatic put_beat(input sample_t v, input bit l,
			input bit typed, input mean_idx_t typed_res);
		bit        has_res;
		mean_idx_t got;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_value <= v;
		last_item <= l;
		do @(posedge clk); while (sample_stall);
		absorb_sample(v, l, has_res, got);
		if (has_res) pending_results.push_back(typed ? typed_res : got);
	endtask

	function automatic sample_t pick_sample(input fill_mode_t m);
		case (m)
			FILL_NARROW: return sample_t'($signed($urandom_range(0, 6)) - 3);
			FILL_EXTREME: begin
				case ($urandom_range(0, 3))
					0: return sample_t'(-32768);
					1: return sample_t'(32767);
					2: return sample_t'(0);
					default: return sample_t'(-1);
				endcase
			end
			default: return sample_t'($urandom_range(0, 65535));
		endcase
	endfunction

	initial begin : stimulus
		mean_idx_t                  typed_res;
		fill_mode_t                 mode;
		sample_t                    v;
		int                         len;
		int                         run_sum;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIRECTED_N; r++) begin
			typed_res.mean_q8 = directed_rows[r].mean_q8;
			typed_res.idx = directed_rows[r].idx;
			for (int k = 0; k < directed_rows[r].reps; k++)
				put_beat(directed_rows[r].value,
					directed_rows[r].last && k == directed_rows[r].reps - 1,
					directed_rows[r].typed, typed_res);
		end

		hold_req = 1'b1;
		for (int run = 0; run < RANDOM_RUNS; run++) begin
			idle_on = (run < RANDOM_RUNS - QUIET_RUNS) && ($urandom_range(0, 3) != 0);
			mode = fill_mode_t'($urandom_range(0, 2));
			len = (run == LONG_RUN) ? $urandom_range(HELD_DEPTH + 1, HELD_DEPTH + 6)
				: $urandom_range(1, 9);
			run_sum = 0;
			for (int k = 0; k < len; k++) begin
				v = pick_sample(mode);
				// steer the final held sample toward the mean
				if (run == LONG_RUN && k == HELD_DEPTH - 1)
					v = sample_t'(run_sum / (HELD_DEPTH - 1));
				run_sum += v;
				put_beat(v, k == len - 1, 1'b0, '0);
			end
		end
		idle_on = 1'b0;
		sample_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : result_drain
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				result_stall <= 1'b1;
				for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
				result_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : result_check
		mean_idx_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: mean %0d index %0d",
					mean_q8, nearest_index));
			end else begin
				want = pending_results.pop_front();
				if (mean_q8 !== want.mean_q8)
					report_mismatch($sformatf("mean_q8 got %0d want %0d",
						mean_q8, want.mean_q8));
				if (nearest_index !== want.idx)
					report_mismatch($sformatf("nearest_index got %0d want %0d",
						nearest_index, want.idx));
			end
		end
	end

	initial begin : watchdog
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
